// ----- hdl/awfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the acceleration window fault detector.
// No dependencies; used by awfd_stats and accel_window_fault_detector.
package awfd_pkg;

    // Configuration register fields.
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 17;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // Register indexes on the config port.
    localparam logic [IDX_W-1:0] REG_THRUST_MS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_GROUND_MAX_MAG = 3'd1;
    localparam logic [IDX_W-1:0] REG_GROUND_MAX_DEV = 3'd2;
    localparam logic [IDX_W-1:0] REG_THRUST_MAX_MAG = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRUST_MAX_DEV = 3'd4;
    localparam logic [IDX_W-1:0] REG_CRUISE_MAX_MAG = 3'd5;
    localparam logic [IDX_W-1:0] REG_CRUISE_MAX_DEV = 3'd6;

    // Reset values.
    localparam logic [TIME_W-1:0]  THRUST_MS_RST      = 32'd15000;
    localparam logic [LIMIT_W-1:0] GROUND_MAX_MAG_RST = 17'd51200;
    localparam logic [LIMIT_W-1:0] GROUND_MAX_DEV_RST = 17'd25600;
    localparam logic [LIMIT_W-1:0] THRUST_MAX_MAG_RST = 17'd38400;
    localparam logic [LIMIT_W-1:0] THRUST_MAX_DEV_RST = 17'd12800;
    localparam logic [LIMIT_W-1:0] CRUISE_MAX_MAG_RST = 17'd12800;
    localparam logic [LIMIT_W-1:0] CRUISE_MAX_DEV_RST = 17'd3840;

    // Flight phase codes.
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PHASE_GROUND = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_THRUST = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CRUISE = 2'd2;

    localparam int COUNT_OUT_W = 3;

    // Sequencer to statistics unit.
    typedef struct packed {
        logic acc_clr;   // start of a new word: clear sums
        logic acc_en;    // one window entry passes the tail
        logic prod_en;   // form n*S2, S1^2, n^2*L^2
        logic cmp_en;    // final deviation compare
    } t_stats_ctl;

endpackage

// ----- hdl/awfd_cell.sv -----
`timescale 1ns / 1ps
// One window cell: holds one sample magnitude, takes its neighbor's value on shift.
// No package dependency.
module awfd_cell #(
    parameter int DATA_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_value;

    // Window starts all zero; unwritten entries add nothing to the sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_data;
        end
    end

    assign o_data = r_value;

endmodule

// ----- hdl/awfd_stats.sv -----
`timescale 1ns / 1ps
// Window sums and exact deviation test n*S2 - S1^2 > n^2*L^2.
// Depends on awfd_pkg (t_stats_ctl, LIMIT_W).
module awfd_stats #(
    parameter int WINDOW_LEN = 5,
    parameter int MAG_W      = 17
) (
    input  logic                                  i_clk,
    input  awfd_pkg::t_stats_ctl                  i_ctl,
    input  logic [MAG_W-1:0]                      i_tail,
    input  logic [$clog2(WINDOW_LEN+1)-1:0]       i_count,
    input  logic [awfd_pkg::LIMIT_W-1:0]          i_max_dev,
    output logic                                  o_dev_over
);

    localparam int CW   = $clog2(WINDOW_LEN + 1);
    localparam int LW   = awfd_pkg::LIMIT_W;
    localparam int S1W  = MAG_W + CW;
    localparam int S2W  = 2 * MAG_W + CW;
    localparam int PW   = 2 * S1W;
    localparam int LHW  = (PW > 64) ? 64 : PW;   // difference kept to at most 64 bits
    localparam int RW   = 2 * CW + 2 * LW;
    localparam int CMPW = (LHW > RW) ? LHW : RW;

    logic [S1W-1:0]    r_s1;
    logic [S2W-1:0]    r_s2;
    logic [2*LW-1:0]   r_lim_sq;
    logic [2*CW-1:0]   r_nn;
    logic [PW-1:0]     r_ns2;
    logic [PW-1:0]     r_s1sq;
    logic [RW-1:0]     r_rhs;
    logic              r_dev_over;

    logic [2*MAG_W-1:0] w_sq;
    logic [2*LW-1:0]    w_lim_sq;
    logic [2*CW-1:0]    w_nn;
    logic [PW-1:0]      w_ns2;
    logic [PW-1:0]      w_s1sq;
    logic [RW-1:0]      w_rhs;
    logic [PW-1:0]      w_diff;
    logic [LHW-1:0]     w_lhs;

    assign w_sq     = i_tail * i_tail;
    assign w_lim_sq = i_max_dev * i_max_dev;
    assign w_nn     = i_count * i_count;
    assign w_ns2    = PW'(i_count) * PW'(r_s2);
    assign w_s1sq   = PW'(r_s1) * PW'(r_s1);
    assign w_rhs    = RW'(r_nn) * RW'(r_lim_sq);
    assign w_diff   = r_ns2 - r_s1sq;
    assign w_lhs    = w_diff[LHW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_ctl.acc_en) begin
            r_s1 <= r_s1 + S1W'(i_tail);
            r_s2 <= r_s2 + S2W'(w_sq);
        end
        if (i_ctl.acc_en) begin
            r_lim_sq <= w_lim_sq;
            r_nn     <= w_nn;
        end
        if (i_ctl.prod_en) begin
            r_ns2  <= w_ns2;
            r_s1sq <= w_s1sq;
            r_rhs  <= w_rhs;
        end
        // fewer than two samples: deviation is zero, never over
        if (i_ctl.cmp_en) begin
            r_dev_over <= (i_count >= CW'(2)) && (CMPW'(w_lhs) > CMPW'(r_rhs));
        end
    end

    assign o_dev_over = r_dev_over;

endmodule

// ----- hdl/accel_window_fault_detector.sv -----
`timescale 1ns / 1ps
// Top level of the acceleration window fault detector: config registers, sequencer,
// window cell chain and output register. Depends on awfd_pkg, awfd_cell, awfd_stats.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word: a signed Q9.8 sample,
//   the current ms tick and the launch time (0 = not launched). Output channel
//   (o_out_valid / i_out_stall) returns one word per input: fault, phase, count.
//   A word moves on a rising edge with valid high and stall low.
//   An accepted word walks the window chain past the single square-and-add unit,
//   one entry per cycle (S_ACC), then passes the product stage (S_PROD) and the
//   compare stage (S_CMP); S_OUT then loads the output register. One word is in
//   work at a time, so a new word is taken only after the last result is loaded.
//   The input is taken again as soon as the result sits in the output register, so a
//   stalled receiver only blocks once a second result is ready.
//   Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high, only
//   while no word is in work. Index 7 is ignored.
//   Reset (synchronous, active low): window cleared, count zero, launch time
//   unlatched, limits back to their defaults, both channels empty.
module accel_window_fault_detector #(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_accel_sample,
    input  logic [awfd_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [awfd_pkg::TIME_W-1:0]          i_launch_ms,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_fault,
    output logic [awfd_pkg::PHASE_W-1:0]         o_phase,
    output logic [awfd_pkg::COUNT_OUT_W-1:0]     o_window_count,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [awfd_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [awfd_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int MAG_W = SAMPLE_BITS - 1;
    localparam int CW    = $clog2(WINDOW_LEN + 1);
    localparam int SW    = $clog2(WINDOW_LEN);
    localparam int LW    = awfd_pkg::LIMIT_W;
    localparam int TW    = awfd_pkg::TIME_W;
    localparam int MCW   = (MAG_W > LW) ? MAG_W : LW;
    localparam logic [SW-1:0] LAST_STEP = SW'(WINDOW_LEN - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_PROD,
        S_CMP,
        S_OUT
    } t_state;

    // ---------------- config registers ----------------
    logic [TW-1:0] r_thrust_ms;
    logic [LW-1:0] r_ground_mag, r_ground_dev;
    logic [LW-1:0] r_thrust_mag, r_thrust_dev;
    logic [LW-1:0] r_cruise_mag, r_cruise_dev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thrust_ms  <= awfd_pkg::THRUST_MS_RST;
            r_ground_mag <= awfd_pkg::GROUND_MAX_MAG_RST;
            r_ground_dev <= awfd_pkg::GROUND_MAX_DEV_RST;
            r_thrust_mag <= awfd_pkg::THRUST_MAX_MAG_RST;
            r_thrust_dev <= awfd_pkg::THRUST_MAX_DEV_RST;
            r_cruise_mag <= awfd_pkg::CRUISE_MAX_MAG_RST;
            r_cruise_dev <= awfd_pkg::CRUISE_MAX_DEV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                awfd_pkg::REG_THRUST_MS:      r_thrust_ms  <= i_cfg_data[TW-1:0];
                awfd_pkg::REG_GROUND_MAX_MAG: r_ground_mag <= i_cfg_data[LW-1:0];
                awfd_pkg::REG_GROUND_MAX_DEV: r_ground_dev <= i_cfg_data[LW-1:0];
                awfd_pkg::REG_THRUST_MAX_MAG: r_thrust_mag <= i_cfg_data[LW-1:0];
                awfd_pkg::REG_THRUST_MAX_DEV: r_thrust_dev <= i_cfg_data[LW-1:0];
                awfd_pkg::REG_CRUISE_MAX_MAG: r_cruise_mag <= i_cfg_data[LW-1:0];
                awfd_pkg::REG_CRUISE_MAX_DEV: r_cruise_dev <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- front end: magnitude, phase, limits ----------------
    t_state r_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    logic [SAMPLE_BITS-1:0] w_neg;
    logic [SAMPLE_BITS-1:0] w_abs;
    logic [MAG_W-1:0]       w_mag;

    // most negative sample has no positive twin: saturate to the largest magnitude
    assign w_neg = ~i_accel_sample + SAMPLE_BITS'(1);
    assign w_abs = i_accel_sample[SAMPLE_BITS-1] ? w_neg : i_accel_sample;
    assign w_mag = w_abs[SAMPLE_BITS-1] ? {MAG_W{1'b1}} : w_abs[MAG_W-1:0];

    logic [TW-1:0]                 r_latched;
    logic [TW-1:0]                 w_launch;
    logic [TW-1:0]                 w_elapsed;
    logic [awfd_pkg::PHASE_W-1:0]  w_phase;
    logic [LW-1:0]                 w_max_mag;
    logic [LW-1:0]                 w_max_dev;

    // any nonzero launch time overwrites the latched one
    assign w_launch  = (i_launch_ms != '0) ? i_launch_ms : r_latched;
    assign w_elapsed = i_now_ms - w_launch;   // wraps mod 2^32

    always_comb begin
        if (w_launch == '0) begin
            w_phase   = awfd_pkg::PHASE_GROUND;
            w_max_mag = r_ground_mag;
            w_max_dev = r_ground_dev;
        end else if (w_elapsed < r_thrust_ms) begin
            w_phase   = awfd_pkg::PHASE_THRUST;
            w_max_mag = r_thrust_mag;
            w_max_dev = r_thrust_dev;
        end else begin
            w_phase   = awfd_pkg::PHASE_CRUISE;
            w_max_mag = r_cruise_mag;
            w_max_dev = r_cruise_dev;
        end
    end

    // ---------------- window cell chain ----------------
    // New magnitude enters at cell 0 and the oldest falls off the end. During the
    // sum walk the chain rotates once, tail feeding head, so it ends where it began.
    logic              w_shift;
    logic [MAG_W-1:0]  w_head;
    logic [MAG_W-1:0]  w_chain [WINDOW_LEN];
    logic [MAG_W-1:0]  w_tail;

    assign w_shift = w_accept || (r_state == S_ACC);
    assign w_tail  = w_chain[WINDOW_LEN-1];
    assign w_head  = w_accept ? w_mag : w_tail;

    genvar g;
    generate
        for (g = 0; g < WINDOW_LEN; g++) begin : g_cell
            if (g == 0) begin : g_first
                awfd_cell #(.DATA_W(MAG_W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_head),
                    .o_data  (w_chain[g])
                );
            end else begin : g_next
                awfd_cell #(.DATA_W(MAG_W)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_data  (w_chain[g-1]),
                    .o_data  (w_chain[g])
                );
            end
        end
    endgenerate

    // ---------------- statistics ----------------
    awfd_pkg::t_stats_ctl w_ctl;
    logic                 w_dev_over;
    logic [CW-1:0]        r_count;
    logic [LW-1:0]        r_max_dev;

    assign w_ctl.acc_clr = w_accept;
    assign w_ctl.acc_en  = (r_state == S_ACC);
    assign w_ctl.prod_en = (r_state == S_PROD);
    assign w_ctl.cmp_en  = (r_state == S_CMP);

    awfd_stats #(
        .WINDOW_LEN (WINDOW_LEN),
        .MAG_W      (MAG_W)
    ) u_stats (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_tail     (w_tail),
        .i_count    (r_count),
        .i_max_dev  (r_max_dev),
        .o_dev_over (w_dev_over)
    );

    // ---------------- sequencer and output register ----------------
    logic [SW-1:0]                 r_step;
    logic                          r_mag_fault;
    logic [awfd_pkg::PHASE_W-1:0]  r_phase;
    logic                          r_out_valid;
    logic                          r_out_fault;
    logic                          r_out_mag_fault;
    logic [awfd_pkg::PHASE_W-1:0]  r_out_phase;
    logic [CW-1:0]                 r_out_count;
    logic                          w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_latched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state     <= S_ACC;
                        r_step      <= '0;
                        r_latched   <= w_launch;
                        r_count     <= (r_count == FULL_CNT) ? r_count : r_count + CW'(1);
                        r_phase     <= w_phase;
                        r_max_dev   <= w_max_dev;
                        r_mag_fault <= MCW'(w_mag) > MCW'(w_max_mag);
                    end
                end
                S_ACC: begin
                    r_step <= r_step + SW'(1);
                    if (r_step == LAST_STEP) begin
                        r_state <= S_PROD;
                    end
                end
                S_PROD: r_state <= S_CMP;
                S_CMP:  r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out_fault     <= r_mag_fault || w_dev_over;
                        r_out_mag_fault <= r_mag_fault;
                        r_out_phase     <= r_phase;
                        r_out_count     <= r_count;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fault        = r_out_fault;
    assign o_phase        = r_out_phase;
    assign o_window_count = awfd_pkg::COUNT_OUT_W'(r_out_count);

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input taken again right after accept");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("result with empty window");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_phase == awfd_pkg::PHASE_GROUND ||
                         r_out_phase == awfd_pkg::PHASE_THRUST ||
                         r_out_phase == awfd_pkg::PHASE_CRUISE))
        else $error("bad phase code");

    a_single_sample_dev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_count < CW'(2)) && !r_out_mag_fault) |-> !r_out_fault)
        else $error("deviation fault with fewer than two samples");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("result dropped while output stalled");

endmodule

// ----- tb/accel_window_fault_detector_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for accel_window_fault_detector: directed table plus random flight words.
// Depends on awfd_pkg and the detector RTL; standalone otherwise.
module accel_window_fault_detector_tb;

    localparam int WIN_LEN = 5;
    localparam int SMP_W   = 18;
    localparam int MAG_W   = SMP_W - 1;
    localparam int MAG_MAX = 2 ** MAG_W - 1;

    localparam int IDX_W   = awfd_pkg::IDX_W;
    localparam int PHASE_W = awfd_pkg::PHASE_W;
    localparam int COUNT_W = awfd_pkg::COUNT_OUT_W;
    localparam int TIME_W  = awfd_pkg::TIME_W;
    localparam int CFG_W   = awfd_pkg::CFG_W;
    localparam int LIM_W   = awfd_pkg::LIMIT_W;

    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {MAG_W{1'b0}}};
    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {MAG_W{1'b1}}};

    // Index 7 has no register behind it; writes there must be dropped.
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    // Settle time for drain(), longer than one word takes through the block.
    localparam int SETTLE_CYCLES = WIN_LEN + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 26;
    localparam int HOLD_CYCLES   = 80;
    localparam int N_DIR         = 21;
    localparam int GROUND_ROWS   = 12;

    typedef struct packed {
        logic               fault;
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] count;
    } t_status;

    typedef struct {
        logic signed [SMP_W-1:0] smp;
        logic [TIME_W-1:0]       now;
        logic [TIME_W-1:0]       launch;
        bit                      typed;
        t_status                 want;
    } t_stim_row;

    // ---------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic signed [SMP_W-1:0]  i_accel_sample = '0;
    logic [TIME_W-1:0]        i_now_ms       = '0;
    logic [TIME_W-1:0]        i_launch_ms    = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic                     o_fault;
    logic [PHASE_W-1:0]       o_phase;
    logic [COUNT_W-1:0]       o_window_count;
    logic                     i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index    = '0;
    logic [CFG_W-1:0]         i_cfg_data     = '0;

    accel_window_fault_detector #(
        .WINDOW_LEN  (WIN_LEN),
        .SAMPLE_BITS (SMP_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_accel_sample (i_accel_sample),
        .i_now_ms       (i_now_ms),
        .i_launch_ms    (i_launch_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fault        (o_fault),
        .o_phase        (o_phase),
        .o_window_count (o_window_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor state: magnitude ring, fill level, held launch time, limits
    // ---------------------------------------------------------------------
    logic [MAG_W-1:0]   win_mag [WIN_LEN];
    int                 wr_slot;
    bit                 win_full;
    logic [TIME_W-1:0]  launch_held;
    logic [TIME_W-1:0]  thrust_ms_r;
    logic [LIM_W-1:0]   lim_mag [3];   // indexed by phase code
    logic [LIM_W-1:0]   lim_dev [3];

    t_status   status_q [$];   // expected status words, oldest first
    t_stim_row dir_rows [N_DIR];

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    int  hold_left    = 0;     // long receiver hold-off, counted down below
    bit  no_idle      = 1'b0;  // suppresses random gaps on both sides
    int  base_level;           // center of the low-spread sample cluster
    logic [TIME_W-1:0] flight_ms;

    // One word through the detector: returns the status it must produce.
    function automatic t_status step_detector(input logic signed [SMP_W-1:0] smp,
                                              input logic [TIME_W-1:0] now,
                                              input logic [TIME_W-1:0] launch);
        t_status            r;
        int                 sv;
        int                 cnt;
        logic [MAG_W-1:0]   mag;
        logic [TIME_W-1:0]  elapsed;
        logic [PHASE_W-1:0] ph;
        longint unsigned    s1, s2, n, m, d;

        // Magnitude; the most negative code saturates to the top magnitude.
        sv = smp;
        if (sv < 0) sv = -sv;
        if (sv > MAG_MAX) sv = MAG_MAX;
        mag = MAG_W'(sv);

        win_mag[wr_slot] = mag;
        wr_slot++;
        if (wr_slot >= WIN_LEN) begin
            wr_slot  = 0;
            win_full = 1'b1;
        end
        cnt = win_full ? WIN_LEN : wr_slot;

        // Any nonzero launch time replaces the held one; zero keeps it.
        if (launch != '0) launch_held = launch;

        if (launch_held == '0) begin
            ph = awfd_pkg::PHASE_GROUND;
        end else begin
            elapsed = now - launch_held;   // wraps mod 2^32
            ph = (elapsed < thrust_ms_r) ? awfd_pkg::PHASE_THRUST : awfd_pkg::PHASE_CRUISE;
        end

        r.fault = (mag > lim_mag[ph]);

        // Population variance test without the root: n*S2 - S1^2 > n^2*L^2.
        if (cnt >= 2) begin
            s1 = 0;
            s2 = 0;
            for (int i = 0; i < cnt; i++) begin
                m = win_mag[i];
                s1 += m;
                s2 += m * m;
            end
            n = cnt;
            d = lim_dev[ph];
            if (n * s2 - s1 * s1 > n * n * d * d) r.fault = 1'b1;
        end

        r.phase = ph;
        r.count = COUNT_W'(cnt);
        return r;
    endfunction

    // Sample picker: raw noise, field extremes, values straddling a magnitude
    // limit, and a tight cluster whose spread sits near a deviation limit.
    function automatic logic signed [SMP_W-1:0] pick_accel();
        int v;
        int span;

        v = 0;
        case ($urandom_range(0, 9))
            0, 1: return SMP_W'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return SMP_MIN;
                    1:       return SMP_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            3, 4, 5: v = int'(lim_mag[$urandom_range(0, 2)]) + int'($urandom_range(0, 4)) - 2;
            default: begin
                span = int'(lim_dev[$urandom_range(0, 2)]);
                if (span < 4) span = 4;
                v = base_level + int'($urandom_range(0, 2 * span)) - span;
            end
        endcase
        if (v < 0) v = 0;
        if (v > MAG_MAX) v = MAG_MAX;
        if ($urandom_range(0, 1) == 1) v = -v;
        return SMP_W'(v);
    endfunction

    task automatic report(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%s", msg);
    endtask

    // ---------------------------------------------------------------------
    // Input side. Valid is set once per falling edge, so a word that follows
    // an accepted one keeps valid high without a low blip.
    // ---------------------------------------------------------------------
    task automatic send_word(input logic signed [SMP_W-1:0] smp,
                             input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] launch,
                             input bit typed,
                             input t_status typed_want);
        t_status pred;

        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_accel_sample <= smp;
        i_now_ms       <= now;
        i_launch_ms    <= launch;
        do @(posedge i_clk); while (o_in_stall);
        // Model always advances; table rows with a typed answer check against it.
        pred = step_detector(smp, now, launch);
        status_q.push_back(typed ? typed_want : pred);
    endtask

    // Stop offering words and let the block empty out completely.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Config writes happen only with the block idle, so the model takes them at once.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            awfd_pkg::REG_THRUST_MS:
                thrust_ms_r = data;
            awfd_pkg::REG_GROUND_MAX_MAG:
                lim_mag[awfd_pkg::PHASE_GROUND] = data[LIM_W-1:0];
            awfd_pkg::REG_GROUND_MAX_DEV:
                lim_dev[awfd_pkg::PHASE_GROUND] = data[LIM_W-1:0];
            awfd_pkg::REG_THRUST_MAX_MAG:
                lim_mag[awfd_pkg::PHASE_THRUST] = data[LIM_W-1:0];
            awfd_pkg::REG_THRUST_MAX_DEV:
                lim_dev[awfd_pkg::PHASE_THRUST] = data[LIM_W-1:0];
            awfd_pkg::REG_CRUISE_MAX_MAG:
                lim_mag[awfd_pkg::PHASE_CRUISE] = data[LIM_W-1:0];
            awfd_pkg::REG_CRUISE_MAX_DEV:
                lim_dev[awfd_pkg::PHASE_CRUISE] = data[LIM_W-1:0];
            default: ;  // unmapped index, dropped
        endcase
    endtask

    task automatic cfg_close();
        write_reg(REG_UNUSED, $urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Same value into every register; upper bits beyond 17 must be masked off in the limit registers.
    task automatic program_all(input logic [CFG_W-1:0] data);
        for (int r = awfd_pkg::REG_THRUST_MS; r <= awfd_pkg::REG_CRUISE_MAX_DEV; r++)
            write_reg(IDX_W'(r), data);
        cfg_close();
    endtask

    task automatic program_defaults();
        write_reg(awfd_pkg::REG_THRUST_MS,      awfd_pkg::THRUST_MS_RST);
        write_reg(awfd_pkg::REG_GROUND_MAX_MAG, CFG_W'(awfd_pkg::GROUND_MAX_MAG_RST));
        write_reg(awfd_pkg::REG_GROUND_MAX_DEV, CFG_W'(awfd_pkg::GROUND_MAX_DEV_RST));
        write_reg(awfd_pkg::REG_THRUST_MAX_MAG, CFG_W'(awfd_pkg::THRUST_MAX_MAG_RST));
        write_reg(awfd_pkg::REG_THRUST_MAX_DEV, CFG_W'(awfd_pkg::THRUST_MAX_DEV_RST));
        write_reg(awfd_pkg::REG_CRUISE_MAX_MAG, CFG_W'(awfd_pkg::CRUISE_MAX_MAG_RST));
        write_reg(awfd_pkg::REG_CRUISE_MAX_DEV, CFG_W'(awfd_pkg::CRUISE_MAX_DEV_RST));
        cfg_close();
    endtask

    task automatic program_random();
        write_reg(awfd_pkg::REG_THRUST_MS, $urandom_range(0, 40000));
        for (int r = awfd_pkg::REG_GROUND_MAX_MAG; r <= awfd_pkg::REG_CRUISE_MAX_DEV; r++)
            write_reg(IDX_W'(r), ($urandom & 32'hFFFE_0000) | $urandom_range(0, 40000));
        cfg_close();
    endtask

    task automatic run_table(input int first, input int last);
        for (int r = first; r <= last; r++)
            send_word(dir_rows[r].smp, dir_rows[r].now, dir_rows[r].launch,
                      dir_rows[r].typed, dir_rows[r].want);
    endtask

    // Random flight words. Time mostly runs forward, with jumps onto the
    // thrust/cruise boundary, near the tick wrap, and anywhere at all.
    task automatic run_random(input int n_words, input bit keep_ground, input bit pause_half);
        logic signed [SMP_W-1:0] smp;
        logic [TIME_W-1:0]       now;
        logic [TIME_W-1:0]       launch;
        int                      pick;

        base_level = $urandom_range(0, 40000);
        for (int k = 0; k < n_words; k++) begin
            smp = pick_accel();
            case ($urandom_range(0, 19))
                0, 1, 2: now = launch_held + thrust_ms_r + $urandom_range(0, 4) - 32'd2;
                3, 4, 5: now = $urandom;
                6, 7:    now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                default: now = flight_ms + $urandom_range(0, 2500);
            endcase
            flight_ms = now;
            pick = $urandom_range(0, 99);
            if (pick < 6)      launch = now - $urandom_range(0, 200);
            else if (pick < 9) launch = $urandom;
            else               launch = '0;
            if (keep_ground) launch = '0;
            send_word(smp, now, launch, 1'b0, '0);
            // With pause_half, the sender waits at the halfway word for every outstanding status.
            if (pause_half && k == n_words / 2) drain();
        end
    endtask

    // ---------------------------------------------------------------------
    // Output side: random stall, plus a long hold-off on request
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Every accepted status word is checked field by field against the oldest
    // expectation.
    always @(posedge i_clk) begin : check_status
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                report($sformatf("status word with nothing expected: fault %0d phase %0d count %0d",
                                 o_fault, o_phase, o_window_count));
            end else begin
                want = status_q.pop_front();
                if (o_fault !== want.fault)
                    report($sformatf("fault: expected %0d, got %0d", want.fault, o_fault));
                if (o_phase !== want.phase)
                    report($sformatf("phase: expected %0d, got %0d", want.phase, o_phase));
                if (o_window_count !== want.count)
                    report($sformatf("window count: expected %0d, got %0d",
                                     want.count, o_window_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("accel_window_fault_detector_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        for (int i = 0; i < WIN_LEN; i++) win_mag[i] = '0;
        wr_slot     = 0;
        win_full    = 1'b0;
        launch_held = '0;
        flight_ms   = '0;
        base_level  = 0;
        thrust_ms_r                     = awfd_pkg::THRUST_MS_RST;
        lim_mag[awfd_pkg::PHASE_GROUND] = awfd_pkg::GROUND_MAX_MAG_RST;
        lim_dev[awfd_pkg::PHASE_GROUND] = awfd_pkg::GROUND_MAX_DEV_RST;
        lim_mag[awfd_pkg::PHASE_THRUST] = awfd_pkg::THRUST_MAX_MAG_RST;
        lim_dev[awfd_pkg::PHASE_THRUST] = awfd_pkg::THRUST_MAX_DEV_RST;
        lim_mag[awfd_pkg::PHASE_CRUISE] = awfd_pkg::CRUISE_MAX_MAG_RST;
        lim_dev[awfd_pkg::PHASE_CRUISE] = awfd_pkg::CRUISE_MAX_DEV_RST;

        // Ground rows first (default limits), then the launch / timing rows.
        dir_rows = '{
            // empty window, count ramps from one
            '{18'sd0,      32'd0, 32'd0, 1'b1, '{1'b0, awfd_pkg::PHASE_GROUND, 3'd1}},
            '{SMP_MAX,     32'd1, 32'd0, 1'b1, '{1'b1, awfd_pkg::PHASE_GROUND, 3'd2}},
            // most negative sample saturates to the top magnitude
            '{SMP_MIN,     32'd2, 32'd0, 1'b1, '{1'b1, awfd_pkg::PHASE_GROUND, 3'd3}},
            '{-18'sd1,     32'd3, 32'd0, 1'b0, '0},
            '{18'sd51200,  32'd4, 32'd0, 1'b0, '0},
            // flush the window with zeros; count stays at full
            '{18'sd0,      32'd5, 32'd0, 1'b0, '0},
            '{18'sd0,      32'd6, 32'd0, 1'b0, '0},
            '{18'sd0,      32'd7, 32'd0, 1'b0, '0},
            '{18'sd0,      32'd8, 32'd0, 1'b0, '0},
            '{18'sd0,      32'd9, 32'd0, 1'b1, '{1'b0, awfd_pkg::PHASE_GROUND, 3'd5}},
            // magnitude on the limit, then one above it
            '{18'sd51200,  32'd10, 32'd0, 1'b0, '0},
            '{-18'sd51201, 32'd11, 32'd0, 1'b0, '0},
            // launch, last thrust tick, first cruise tick
            '{18'sd100,    32'd1000,  32'd1000, 1'b0, '0},
            '{-18'sd100,   32'd15999, 32'd0,    1'b0, '0},
            '{18'sd100,    32'd16000, 32'd0,    1'b0, '0},
            // a second launch time overwrites the held one
            '{18'sd0,      32'd20000, 32'd20000, 1'b0, '0},
            // elapsed time across the tick wrap
            '{18'sd3840,   32'h0000_0010, 32'hFFFF_FFF0, 1'b0, '0},
            '{-18'sd3840,  32'hFFFF_FFFF, 32'd0,         1'b0, '0},
            '{18'sd12801,  32'hFFFF_FFEF, 32'd0,         1'b0, '0},
            '{SMP_MIN,     32'h3A98_0000, 32'd0,         1'b0, '0},
            '{18'sd1,      32'd0,         32'd0,         1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_table(0, GROUND_ROWS - 1);
        drain();

        // Ground is only reachable before any launch, so cover its limits now.
        // The receiver holds off first so the block fills and stalls its input.
        program_all(32'hFFFF_FFFF);
        hold_left = HOLD_CYCLES;
        run_random(50, 1'b1, 1'b0);
        drain();
        program_all('0);
        run_random(50, 1'b1, 1'b0);
        drain();

        program_defaults();
        run_table(GROUND_ROWS, N_DIR - 1);
        drain();

        run_random(75, 1'b0, 1'b1);
        drain();
        // thrust window never closes except at elapsed = 2^32 - 1
        program_all(32'hFFFF_FFFF);
        run_random(75, 1'b0, 1'b0);
        drain();
        // zero thrust window: straight to cruise, every nonzero sample faults
        program_all('0);
        run_random(75, 1'b0, 1'b0);
        drain();
        // random limits, back-to-back words with no gaps on either side
        program_random();
        no_idle = 1'b1;
        run_random(75, 1'b0, 1'b0);
        no_idle = 1'b0;
        drain();

        if (mismatch_cnt == 0) begin
            $display("accel_window_fault_detector_tb passed");
        end else begin
            $display("accel_window_fault_detector_tb failed");
        end
        $finish;
    end

endmodule
